// ----- hw/rtl/tak_pkg.sv -----
// Shared types, constants and helper functions for the tilt angle Kalman filter.
// Holds the word format, the microcode program of the sequencer and the saturation helpers.
// Depends on nothing; every other RTL file of the block uses it.
package tak_pkg;

	localparam int WORD_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int MAG_W     = PROD_W - FRAC_W;
	localparam int DVD_W     = WORD_W + FRAC_W;
	localparam int DIV_CNT_W = $clog2(DVD_W);
	localparam int STEP_W    = 5;
	localparam int CFG_W     = 24;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [MAG_W-1:0] MAG_NEG_LIM = MAG_W'(1) << (WORD_W - 1);
	localparam logic [MAG_W-1:0] MAG_POS_LIM = MAG_NEG_LIM - MAG_W'(1);

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	// Operand and destination registers of the datapath.
	typedef enum logic [4:0] {
		R_ANG,
		R_BIAS,
		R_AA,
		R_AB,
		R_BA,
		R_BB,
		R_MEAS,
		R_GYRO,
		R_T0,
		R_T1,
		R_T2,
		R_T3,
		R_T4,
		R_T5,
		R_K0,
		R_K1,
		R_DT,
		R_QA,
		R_QB,
		R_R
	} rsel_t;

	typedef enum logic [1:0] {
		CFG_TIME_STEP   = 2'd0,
		CFG_ANGLE_NOISE = 2'd1,
		CFG_BIAS_NOISE  = 2'd2,
		CFG_MEAS_NOISE  = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_MUL_WB,
		S_DIV_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t   op;
		rsel_t a;
		rsel_t b;
		rsel_t dst;
		logic  last;
	} uop_t;

	// Applies a sign to a magnitude and clamps the result to the word range.
	function automatic word_t sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
		logic [MAG_W-1:0] neg_mag;
		neg_mag = -mag;
		if (neg) begin
			if (mag > MAG_NEG_LIM)
				return WORD_MIN;
			return neg_mag[WORD_W-1:0];
		end
		if (mag > MAG_POS_LIM)
			return WORD_MAX;
		return mag[WORD_W-1:0];
	endfunction

	// Saturating add or subtract of two words.
	function automatic word_t sat_addsub(input word_t a, input word_t b, input logic do_sub);
		logic signed [WORD_W:0] s;
		if (do_sub)
			s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		else
			s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1])
			return s[WORD_W] ? WORD_MIN : WORD_MAX;
		return s[WORD_W-1:0];
	endfunction

	// One filter update as a list of operations on the shared unit.
	function automatic uop_t ucode(input logic [STEP_W-1:0] pc);
		uop_t u;
		unique case (pc)
			5'd0:    u = '{OP_SUB, R_GYRO, R_BIAS, R_T0,   1'b0};
			5'd1:    u = '{OP_MUL, R_T0,   R_DT,   R_T0,   1'b0};
			5'd2:    u = '{OP_ADD, R_ANG,  R_T0,   R_ANG,  1'b0};
			5'd3:    u = '{OP_MUL, R_BB,   R_DT,   R_T1,   1'b0};
			5'd4:    u = '{OP_SUB, R_QA,   R_AB,   R_T2,   1'b0};
			5'd5:    u = '{OP_SUB, R_T2,   R_BA,   R_T2,   1'b0};
			5'd6:    u = '{OP_MUL, R_T2,   R_DT,   R_T2,   1'b0};
			5'd7:    u = '{OP_ADD, R_AA,   R_T2,   R_T2,   1'b0};
			5'd8:    u = '{OP_MUL, R_T1,   R_DT,   R_T3,   1'b0};
			5'd9:    u = '{OP_ADD, R_T2,   R_T3,   R_T2,   1'b0};
			5'd10:   u = '{OP_SUB, R_AB,   R_T1,   R_T3,   1'b0};
			5'd11:   u = '{OP_SUB, R_BA,   R_T1,   R_T4,   1'b0};
			5'd12:   u = '{OP_ADD, R_BB,   R_QB,   R_BB,   1'b0};
			5'd13:   u = '{OP_ADD, R_T2,   R_R,    R_T5,   1'b0};
			5'd14:   u = '{OP_DIV, R_T2,   R_T5,   R_K0,   1'b0};
			5'd15:   u = '{OP_DIV, R_T4,   R_T5,   R_K1,   1'b0};
			5'd16:   u = '{OP_SUB, R_MEAS, R_ANG,  R_T0,   1'b0};
			5'd17:   u = '{OP_MUL, R_K0,   R_T0,   R_T1,   1'b0};
			5'd18:   u = '{OP_ADD, R_ANG,  R_T1,   R_ANG,  1'b0};
			5'd19:   u = '{OP_MUL, R_K1,   R_T0,   R_T1,   1'b0};
			5'd20:   u = '{OP_ADD, R_BIAS, R_T1,   R_BIAS, 1'b0};
			5'd21:   u = '{OP_MUL, R_K0,   R_T2,   R_T1,   1'b0};
			5'd22:   u = '{OP_SUB, R_T2,   R_T1,   R_AA,   1'b0};
			5'd23:   u = '{OP_MUL, R_K0,   R_T3,   R_T1,   1'b0};
			5'd24:   u = '{OP_SUB, R_T3,   R_T1,   R_AB,   1'b0};
			5'd25:   u = '{OP_MUL, R_K1,   R_T2,   R_T1,   1'b0};
			5'd26:   u = '{OP_SUB, R_T4,   R_T1,   R_BA,   1'b0};
			5'd27:   u = '{OP_MUL, R_K1,   R_T3,   R_T1,   1'b0};
			5'd28:   u = '{OP_SUB, R_BB,   R_T1,   R_BB,   1'b1};
			default: u = '{OP_ADD, R_T5,   R_T5,   R_T5,   1'b1};
		endcase
		return u;
	endfunction

endpackage

// ----- hw/rtl/tak_mul.sv -----
// Shared fixed-point multiplier of the tilt angle Kalman filter.
// Registers the full magnitude product, then rounds half away from zero and saturates.
// Depends on tak_pkg.
module tak_mul (
	input  logic          clk,
	input  logic          en,
	input  tak_pkg::word_t a,
	input  tak_pkg::word_t b,
	output tak_pkg::word_t res
);

	logic [tak_pkg::WORD_W-1:0] mag_a;
	logic [tak_pkg::WORD_W-1:0] mag_b;
	logic [tak_pkg::PROD_W-1:0] prod_q;
	logic                       neg_q;
	logic [tak_pkg::PROD_W-1:0] rnd;

	assign mag_a = a[tak_pkg::WORD_W-1] ? -a : a;
	assign mag_b = b[tak_pkg::WORD_W-1] ? -b : b;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_q  <= a[tak_pkg::WORD_W-1] ^ b[tak_pkg::WORD_W-1];
			prod_q <= tak_pkg::PROD_W'(mag_a) * tak_pkg::PROD_W'(mag_b);
		end
	end

	assign rnd = prod_q + (tak_pkg::PROD_W'(1) << (tak_pkg::FRAC_W - 1));
	assign res = tak_pkg::sat_mag(neg_q, rnd[tak_pkg::PROD_W-1:tak_pkg::FRAC_W]);

endmodule

// ----- hw/rtl/tak_div.sv -----
// Bit-serial restoring divider of the tilt angle Kalman filter, one quotient bit a cycle.
// Gives the fixed-point quotient truncated toward zero, or zero for a divisor that is not positive.
// Depends on tak_pkg.
module tak_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tak_pkg::word_t num,
	input  tak_pkg::word_t den,
	output logic          done,
	output tak_pkg::word_t quo
);

	logic                          busy_q;
	logic                          done_q;
	logic [tak_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [tak_pkg::WORD_W-1:0]    rem_q;
	logic [tak_pkg::WORD_W-1:0]    den_q;
	logic [tak_pkg::DVD_W-1:0]     dvd_q;
	logic                          neg_q;
	logic [tak_pkg::WORD_W-1:0]    num_mag;
	logic [tak_pkg::WORD_W:0]      trial;
	logic                          fits;

	assign num_mag = num[tak_pkg::WORD_W-1] ? -num : num;
	assign trial   = {rem_q, dvd_q[tak_pkg::DVD_W-1]};
	assign fits    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (!den[tak_pkg::WORD_W-1] && |den)
					busy_q <= 1'b1;
				else
					done_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == tak_pkg::DIV_CNT_W'(tak_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[tak_pkg::WORD_W-1];
			if (!den[tak_pkg::WORD_W-1] && |den)
				dvd_q <= {num_mag, {tak_pkg::FRAC_W{1'b0}}};
			else
				dvd_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial[tak_pkg::WORD_W-1:0] - den_q : trial[tak_pkg::WORD_W-1:0];
			dvd_q <= {dvd_q[tak_pkg::DVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = tak_pkg::sat_mag(neg_q, tak_pkg::MAG_W'(dvd_q));

endmodule

// ----- hw/rtl/tilt_angle_kalman_filter.sv -----
// Top level of the tilt angle Kalman filter: sequencer, register file and output register.
// Depends on tak_pkg, tak_mul and tak_div.
//
// Usage:
// The input channel (in_valid, in_ready) takes one word of measured_angle and gyro_rate,
// both signed Q16.16. The output channel (out_valid, out_ready) returns one word of
// filtered_angle and bias_estimate for each input word, in order.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes time_step,
// angle_process_noise, bias_process_noise and measure_noise at indexes 0 to 3; it is always
// ready and should only be used while no update is in flight.
// A microcoded sequencer runs 29 operations through one saturating adder, one registered
// multiplier and one bit-serial divider. A gain division skips the bit-serial loop when the
// innovation denominator is not positive. The block takes no new word until the result of
// the current update has moved to the output register; in_ready is high only while the
// block is idle.
// A finished result sits in the output register; the block accepts the next word while
// it waits, and a new result waits in the sequencer until the previous one is taken.
// Reset restores the default configuration, clears the angle and bias estimates and sets
// the covariance to the identity.
module tilt_angle_kalman_filter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [31:0]        measured_angle,
	input  logic signed [31:0]        gyro_rate,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [31:0]        filtered_angle,
	output logic signed [31:0]        bias_estimate,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [tak_pkg::CFG_W-1:0] cfg_data
);

	tak_pkg::state_t state_q, state_d;
	logic [tak_pkg::STEP_W-1:0] pc_q;
	tak_pkg::uop_t uop;

	logic [15:0] time_step_q;
	logic [15:0] angle_noise_q;
	logic [15:0] bias_noise_q;
	logic [23:0] meas_noise_q;

	tak_pkg::word_t ang_q, bias_q, aa_q, ab_q, ba_q, bb_q;
	tak_pkg::word_t meas_q, gyro_q;
	tak_pkg::word_t t0_q, t1_q, t2_q, t3_q, t4_q, t5_q, k0_q, k1_q;

	tak_pkg::word_t opa, opb, alu_res, mul_res, div_res, wb_data;
	logic wb_en, adv, pc_inc, mul_en, div_start, div_done, out_load, in_take;

	logic                out_valid_q;
	tak_pkg::word_t      filtered_angle_q;
	tak_pkg::word_t      bias_estimate_q;

	assign uop = tak_pkg::ucode(pc_q);

	function automatic tak_pkg::word_t pick(input tak_pkg::rsel_t sel);
		tak_pkg::word_t v;
		unique case (sel)
			tak_pkg::R_ANG:  v = ang_q;
			tak_pkg::R_BIAS: v = bias_q;
			tak_pkg::R_AA:   v = aa_q;
			tak_pkg::R_AB:   v = ab_q;
			tak_pkg::R_BA:   v = ba_q;
			tak_pkg::R_BB:   v = bb_q;
			tak_pkg::R_MEAS: v = meas_q;
			tak_pkg::R_GYRO: v = gyro_q;
			tak_pkg::R_T0:   v = t0_q;
			tak_pkg::R_T1:   v = t1_q;
			tak_pkg::R_T2:   v = t2_q;
			tak_pkg::R_T3:   v = t3_q;
			tak_pkg::R_T4:   v = t4_q;
			tak_pkg::R_T5:   v = t5_q;
			tak_pkg::R_K0:   v = k0_q;
			tak_pkg::R_K1:   v = k1_q;
			tak_pkg::R_DT:   v = {16'b0, time_step_q};
			tak_pkg::R_QA:   v = {16'b0, angle_noise_q};
			tak_pkg::R_QB:   v = {16'b0, bias_noise_q};
			tak_pkg::R_R:    v = {8'b0, meas_noise_q};
			default:         v = '0;
		endcase
		return v;
	endfunction

	// The operand muxes must follow the registers as well as the selects.
	always_comb begin
		opa = pick(uop.a);
		opb = pick(uop.b);
	end

	assign alu_res = tak_pkg::sat_addsub(opa, opb, uop.op == tak_pkg::OP_SUB);

	tak_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (opa),
		.b   (opb),
		.res (mul_res)
	);

	tak_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (opa),
		.den    (opb),
		.done   (div_done),
		.quo    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tak_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		wb_en     = 1'b0;
		wb_data   = alu_res;
		adv       = 1'b0;
		pc_inc    = 1'b0;
		mul_en    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		in_take   = 1'b0;
		unique case (state_q)
			tak_pkg::S_IDLE: begin
				if (in_valid) begin
					in_take = 1'b1;
					state_d = tak_pkg::S_ISSUE;
				end
			end
			tak_pkg::S_ISSUE: begin
				case (uop.op) inside
					tak_pkg::OP_ADD, tak_pkg::OP_SUB: begin
						wb_en = 1'b1;
						adv   = 1'b1;
					end
					tak_pkg::OP_MUL: begin
						mul_en  = 1'b1;
						state_d = tak_pkg::S_MUL_WB;
					end
					default: begin
						div_start = 1'b1;
						state_d   = tak_pkg::S_DIV_WAIT;
					end
				endcase
			end
			tak_pkg::S_MUL_WB: begin
				wb_en   = 1'b1;
				wb_data = mul_res;
				adv     = 1'b1;
			end
			tak_pkg::S_DIV_WAIT: begin
				if (div_done) begin
					wb_en   = 1'b1;
					wb_data = div_res;
					adv     = 1'b1;
				end
			end
			tak_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = tak_pkg::S_IDLE;
				end
			end
			default: state_d = tak_pkg::S_IDLE;
		endcase
		if (adv) begin
			if (uop.last) begin
				state_d = tak_pkg::S_DONE;
			end else begin
				pc_inc  = 1'b1;
				state_d = tak_pkg::S_ISSUE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= '0;
		else if (in_take)
			pc_q <= '0;
		else if (pc_inc)
			pc_q <= pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q   <= 16'd328;
			angle_noise_q <= 16'd66;
			bias_noise_q  <= 16'd197;
			meas_noise_q  <= 24'd32768;
		end else if (cfg_valid && cfg_ready) begin
			unique case (tak_pkg::cfg_idx_t'(cfg_index))
				tak_pkg::CFG_TIME_STEP:   time_step_q   <= cfg_data[15:0];
				tak_pkg::CFG_ANGLE_NOISE: angle_noise_q <= cfg_data[15:0];
				tak_pkg::CFG_BIAS_NOISE:  bias_noise_q  <= cfg_data[15:0];
				tak_pkg::CFG_MEAS_NOISE:  meas_noise_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Filter state, restored to the initial estimate and identity covariance by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q  <= '0;
			bias_q <= '0;
			aa_q   <= tak_pkg::word_t'(1) <<< tak_pkg::FRAC_W;
			ab_q   <= '0;
			ba_q   <= '0;
			bb_q   <= tak_pkg::word_t'(1) <<< tak_pkg::FRAC_W;
		end else if (wb_en) begin
			unique case (uop.dst)
				tak_pkg::R_ANG:  ang_q  <= wb_data;
				tak_pkg::R_BIAS: bias_q <= wb_data;
				tak_pkg::R_AA:   aa_q   <= wb_data;
				tak_pkg::R_AB:   ab_q   <= wb_data;
				tak_pkg::R_BA:   ba_q   <= wb_data;
				tak_pkg::R_BB:   bb_q   <= wb_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			meas_q <= measured_angle;
			gyro_q <= gyro_rate;
		end
		if (wb_en) begin
			unique case (uop.dst)
				tak_pkg::R_T0: t0_q <= wb_data;
				tak_pkg::R_T1: t1_q <= wb_data;
				tak_pkg::R_T2: t2_q <= wb_data;
				tak_pkg::R_T3: t3_q <= wb_data;
				tak_pkg::R_T4: t4_q <= wb_data;
				tak_pkg::R_T5: t5_q <= wb_data;
				tak_pkg::R_K0: k0_q <= wb_data;
				tak_pkg::R_K1: k1_q <= wb_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_angle_q <= ang_q;
			bias_estimate_q  <= bias_q;
		end
	end

	assign in_ready       = state_q == tak_pkg::S_IDLE;
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign filtered_angle = filtered_angle_q;
	assign bias_estimate  = bias_estimate_q;

endmodule

// ----- sim/tb_tilt_angle_kalman_filter.sv -----
// Self-checking testbench for the tilt angle Kalman filter: drives angle and rate words,
// follows the filter state in a scoreboard class and compares every returned estimate.
// Depends on tak_pkg and the tilt_angle_kalman_filter RTL; reads no files.
module tb_tilt_angle_kalman_filter;
	timeunit 1ns;
	timeprecision 1ps;

	import tak_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 700;
	localparam int CHUNKS       = 8;
	localparam int CHUNK_WORDS  = 238;
	localparam int TAIL_CYCLES  = 150;
	localparam int ANGLE_SPAN   = 90 * 65536;
	localparam int RATE_SPAN    = 250 * 65536;

	typedef struct {
		word_t angle;
		word_t bias;
	} estimate_t;

	// Follows the filter state and holds the estimates still owed by the block.
	class kalman_tracker;
		logic [15:0] step_q, angle_noise, bias_noise;
		logic [23:0] meas_var;
		word_t angle, bias, p_aa, p_ab, p_ba, p_bb;
		estimate_t expected[$];
		int mismatches;

		function new();
			step_q      = 16'd328;
			angle_noise = 16'd66;
			bias_noise  = 16'd197;
			meas_var    = 24'd32768;
			angle       = '0;
			bias        = '0;
			p_aa        = word_t'(32'd65536);
			p_ab        = '0;
			p_ba        = '0;
			p_bb        = word_t'(32'd65536);
			mismatches  = 0;
		endfunction

		static function word_t clip_word(longint v);
			if (v > longint'(WORD_MAX))
				return WORD_MAX;
			if (v < longint'(WORD_MIN))
				return WORD_MIN;
			return v[31:0];
		endfunction

		static function word_t sat_sum(word_t a, word_t b);
			return clip_word(longint'(a) + longint'(b));
		endfunction

		static function word_t sat_diff(word_t a, word_t b);
			return clip_word(longint'(a) - longint'(b));
		endfunction

		// Product rounded half away from zero.
		static function word_t fx_mul(word_t a, word_t b);
			logic neg;
			longint unsigned ma, mb, mag;
			neg = (a < 0) != (b < 0);
			ma  = (a < 0) ? -longint'(a) : longint'(a);
			mb  = (b < 0) ? -longint'(b) : longint'(b);
			mag = (ma * mb + 64'd32768) >> FRAC_W;
			return clip_word(neg ? -longint'(mag) : longint'(mag));
		endfunction

		// Quotient truncated toward zero; the divisor is always positive here.
		static function word_t fx_div(word_t n, word_t d);
			longint unsigned mag, dv;
			dv  = longint'(d);
			mag = (n < 0) ? -longint'(n) : longint'(n);
			mag = (mag << FRAC_W) / dv;
			return clip_word((n < 0) ? -longint'(mag) : longint'(mag));
		endfunction

		function void set_register(cfg_idx_t idx, logic [23:0] value);
			case (idx)
				CFG_TIME_STEP:   step_q      = value[15:0];
				CFG_ANGLE_NOISE: angle_noise = value[15:0];
				CFG_BIAS_NOISE:  bias_noise  = value[15:0];
				CFG_MEAS_NOISE:  meas_var    = value;
				default: ;
			endcase
		endfunction

		// One filter update for an accepted word; queues the estimate it produces.
		function void take_sample(word_t meas, word_t rate);
			word_t dt, qa, qb, r, bbdt, aa, ab, ba, bb, den, k0, k1, err;
			dt = word_t'({16'd0, step_q});
			qa = word_t'({16'd0, angle_noise});
			qb = word_t'({16'd0, bias_noise});
			r  = word_t'({8'd0, meas_var});

			angle = sat_sum(angle, fx_mul(sat_diff(rate, bias), dt));
			bbdt  = fx_mul(p_bb, dt);
			aa    = sat_sum(sat_sum(p_aa, fx_mul(sat_diff(sat_diff(qa, p_ab), p_ba), dt)),
				fx_mul(bbdt, dt));
			ab    = sat_diff(p_ab, bbdt);
			ba    = sat_diff(p_ba, bbdt);
			bb    = sat_sum(p_bb, qb);

			// A denominator that is not positive leaves both gains at zero.
			den = sat_sum(aa, r);
			k0  = '0;
			k1  = '0;
			if (den > 0) begin
				k0 = fx_div(aa, den);
				k1 = fx_div(ba, den);
			end

			err   = sat_diff(meas, angle);
			angle = sat_sum(angle, fx_mul(k0, err));
			bias  = sat_sum(bias, fx_mul(k1, err));

			// The covariance update uses the predicted values, not the corrected ones.
			p_aa = sat_diff(aa, fx_mul(k0, aa));
			p_ab = sat_diff(ab, fx_mul(k0, ab));
			p_ba = sat_diff(ba, fx_mul(k1, aa));
			p_bb = sat_diff(bb, fx_mul(k1, ab));

			expected.push_back('{angle, bias});
		endfunction

		function void check_estimate(word_t got_angle, word_t got_bias);
			estimate_t e;
			if (expected.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word, angle %0d bias %0d", $time, got_angle,
					got_bias);
				return;
			end
			e = expected.pop_front();
			if (got_angle !== e.angle) begin
				mismatches++;
				$display("%0t: filtered_angle expected %0d, got %0d", $time, e.angle,
					got_angle);
			end
			if (got_bias !== e.bias) begin
				mismatches++;
				$display("%0t: bias_estimate expected %0d, got %0d", $time, e.bias,
					got_bias);
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic signed [31:0] measured_angle;
	logic signed [31:0] gyro_rate;
	logic              out_valid;
	logic              out_ready;
	logic signed [31:0] filtered_angle;
	logic signed [31:0] bias_estimate;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	kalman_tracker tracker;
	int            send_idle_pct;
	int            stall_pct;
	logic          hold_req;
	int            quiet_cycles;

	tilt_angle_kalman_filter uut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.measured_angle,
		.gyro_rate,
		.out_valid,
		.out_ready,
		.filtered_angle,
		.bias_estimate,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.set_register(cfg_idx_t'(cfg_index), cfg_data);
			if (in_valid && in_ready)
				tracker.take_sample(measured_angle, gyro_rate);
			if (out_valid && out_ready)
				tracker.check_estimate(filtered_angle, bias_estimate);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("tilt_angle_kalman_filter regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Output side: random stalls, plus one long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Called at a falling edge; returns at a falling edge with in_valid still high.
	task automatic send_sample(input word_t angle, input word_t rate);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		measured_angle <= angle;
		gyro_rate      <= rate;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Unused upper bits of the 16-bit registers carry random junk.
	task automatic load_config(input logic [15:0] dt, qa, qb, input logic [23:0] r);
		write_reg(CFG_TIME_STEP, {8'($urandom), dt});
		write_reg(CFG_ANGLE_NOISE, {8'($urandom), qa});
		write_reg(CFG_BIAS_NOISE, {8'($urandom), qb});
		write_reg(CFG_MEAS_NOISE, r);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_config();
		if ($urandom_range(3) == 0)
			load_config(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
		else
			load_config(16'($urandom_range(2000, 50)), 16'($urandom_range(400)),
				16'($urandom_range(1200)), 24'($urandom_range(300000, 2000)));
	endtask

	// Stops offering and waits until every owed estimate has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.expected.size() != 0)
			@(negedge clk);
	endtask

	function automatic word_t pick_value(input int span);
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 70)
			return word_t'($urandom_range(2 * span)) - span;
		if (sel < 90)
			return word_t'($urandom);
		case ($urandom_range(3))
			0:       return WORD_MAX;
			1:       return WORD_MIN;
			2:       return '0;
			default: return '1;
		endcase
	endfunction

	initial begin
		tracker        = new();
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		measured_angle = '0;
		gyro_rate      = '0;
		out_ready      = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		send_idle_pct  = 0;
		stall_pct      = 0;
		hold_req       = 1'b0;
		quiet_cycles   = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Default settings: field extremes and a couple of ordinary words.
		send_sample('0, '0);
		send_sample(WORD_MAX, WORD_MAX);
		send_sample(WORD_MIN, WORD_MIN);
		send_sample(WORD_MAX, WORD_MIN);
		send_sample(WORD_MIN, WORD_MAX);
		send_sample('1, word_t'(1));
		send_sample(word_t'(30 * 65536), word_t'(2 * 65536));
		send_sample(-word_t'(45 * 65536), -word_t'(10 * 65536));
		drain();

		// Zero time step and zero noise: the first update drives the angle variance
		// to zero, so later updates see a denominator that is not positive.
		load_config('0, '0, '0, '0);
		send_sample(word_t'(10 * 65536), word_t'(5 * 65536));
		send_sample(word_t'(20 * 65536), '0);
		send_sample(WORD_MIN, WORD_MAX);
		drain();

		// Every register at its top value.
		load_config('1, '1, '1, '1);
		send_sample(WORD_MAX, WORD_MIN);
		send_sample(WORD_MIN, WORD_MAX);
		send_sample('0, '0);
		send_sample(word_t'(12345678), -word_t'(7654321));
		drain();

		// Smallest nonzero step and measurement noise.
		load_config(16'd1, '0, '1, 24'd1);
		send_sample(word_t'(5 * 65536), word_t'(65536));
		send_sample(-word_t'(5 * 65536), WORD_MAX);
		send_sample(WORD_MAX, '0);
		drain();

		for (int c = 0; c < CHUNKS; c++) begin
			random_config();
			case (c % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 72; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 72; end
				default: begin send_idle_pct = 23; stall_pct = 23; end
			endcase
			// Hold the output off long enough for the block to fill and refuse input.
			if (c == 4)
				hold_req = 1'b1;
			for (int i = 0; i < CHUNK_WORDS; i++)
				send_sample(pick_value(ANGLE_SPAN), pick_value(RATE_SPAN));
			drain();
		end

		stall_pct = 0;
		repeat (TAIL_CYCLES) @(negedge clk);
		if (tracker.mismatches == 0)
			$display("tilt_angle_kalman_filter regression: pass");
		else
			$display("tilt_angle_kalman_filter regression: fail");
		$finish;
	end

endmodule
